[rtl/core/vfb_pkg.sv]
// ----------------------------------------------------------------------------
// vfb_pkg: shared types, constants and coefficient table of the filter bank
// Holds the fixed-point widths, the controller/datapath command types and the
// Q10.53 coefficient table built at elaboration from exact decimal values.
// ----------------------------------------------------------------------------
`default_nettype none

package vfb_pkg;

   localparam int FILTER_ORDER = 10;
   localparam int VOWEL_COUNT  = 5;
   localparam int TAP_COUNT    = FILTER_ORDER + 1;
   localparam int HIST_DEPTH   = FILTER_ORDER * VOWEL_COUNT;
   localparam int COEF_FRAC    = 53;
   localparam int MIX_FRAC     = 40;
   localparam int ACC_W        = 128;
   localparam int POS_W        = 19;
   localparam logic [POS_W-1:0] POS_MAX = 19'd262144;

   // Divide by ten as floor(n * DIV_RECIP / 2^DIV_SHIFT), exact for n < 2^50.
   localparam logic [63:0] DIV_RECIP = 64'd450359962737050;
   localparam int          DIV_SHIFT = 52;

   // Coefficient = mantissa / 10^exponent. Tap 0 is the gain.
   localparam longint COEF_MANT [VOWEL_COUNT][TAP_COUNT] = '{
      '{ 64'sd811044, 64'sd8943665402, -64'sd3683889529, 64'sd9201697887,
         -64'sd154337906, 64'sd1816233289, -64'sd1518651235, 64'sd8909614114,
         -64'sd3510298511, 64'sd8388101016, -64'sd923313471 },
      '{ 64'sd436215, 64'sd890438318, -64'sd3655179099, 64'sd9105750846,
         -64'sd152422234, 64'sd1791170248, -64'sd1496496211, 64'sd8778352223,
         -64'sd3460687431, 64'sd8282228154, -64'sd914150747 },
      '{ 64'sd333819, 64'sd8893102966, -64'sd3649532826, 64'sd9096543286,
         -64'sd1524545478, 64'sd1794835618, -64'sd150315433, 64'sd8843409371,
         -64'sd3498612086, 64'sd8407803364, -64'sd932568035 },
      '{ 64'sd113572, 64'sd8994734087, -64'sd372084849, 64'sd9322900521,
         -64'sd1566929844, 64'sd184596544, -64'sd1543755513, 64'sd9049663749,
         -64'sd3558964535, 64'sd8478996281, -64'sd929252233 },
      '{ 64'sd409431, 64'sd8997322763, -64'sd3720218544, 64'sd9311385476,
         -64'sd1562530937, 64'sd1837080141, -64'sd1532631681, 64'sd8959539726,
         -64'sd3512454591, 64'sd8338655623, -64'sd910251753 }
   };

   localparam int COEF_EXP [VOWEL_COUNT][TAP_COUNT] = '{
      '{ 11, 9, 8, 8, 6, 7, 7, 8, 8, 9, 9 },
      '{ 11, 8, 8, 8, 6, 7, 7, 8, 8, 9, 9 },
      '{ 11, 9, 8, 8, 7, 7, 6, 8, 8, 9, 9 },
      '{ 11, 9, 7, 8, 7, 6, 7, 8, 8, 9, 9 },
      '{ 12, 9, 8, 8, 7, 7, 7, 8, 8, 9, 9 }
   };

   typedef logic [VOWEL_COUNT-1:0][TAP_COUNT-1:0][63:0] coef_table_type;

   // Rounds each coefficient to Q10.53 by restoring long division.
   function automatic coef_table_type build_coef_table();
      coef_table_type tbl;
      longint         m;
      logic [63:0]    n;
      logic [63:0]    d;
      logic [63:0]    q;
      logic [63:0]    r;
      int             v;
      int             k;
      int             i;
      tbl = '0;
      for (v = 0; v < VOWEL_COUNT; v++) begin
         for (k = 0; k < TAP_COUNT; k++) begin
            m = COEF_MANT[v][k];
            n = (m < 0) ? 64'(-m) : 64'(m);
            d = 64'd1;
            for (i = 0; i < COEF_EXP[v][k]; i++) begin
               d = d * 64'd10;
            end
            q = '0;
            r = '0;
            for (i = 63; i >= 0; i--) begin
               r = {r[62:0], n[i]};
               q = {q[62:0], 1'b0};
               if (r >= d) begin
                  r    = r - d;
                  q[0] = 1'b1;
               end
            end
            for (i = 0; i < COEF_FRAC; i++) begin
               r = {r[62:0], 1'b0};
               q = {q[62:0], 1'b0};
               if (r >= d) begin
                  r    = r - d;
                  q[0] = 1'b1;
               end
            end
            if ({r[62:0], 1'b0} >= d) begin
               q = q + 64'd1;
            end
            tbl[v][k] = (m < 0) ? (~q + 64'd1) : q;
         end
      end
      return tbl;
   endfunction

   localparam coef_table_type COEF_TABLE = build_coef_table();

   typedef enum logic [1:0] {
      SRC_X,
      SRC_HIST,
      SRC_MIX_LO,
      SRC_MIX_HI
   } op_src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DIV_DONE,
      ST_FETCH,
      ST_LOAD,
      ST_MULT,
      ST_FILT_ROUND,
      ST_MIX_LOAD,
      ST_MIX_MULT,
      ST_MIX_ROUND,
      ST_EMIT
   } fb_state_type;

   typedef struct packed {
      logic       start;
      logic       clear_hist;
      logic       cfg_write;
      logic       div_done;
      logic       fetch;
      logic       load;
      logic       mul;
      logic [1:0] part;
      op_src_type src;
      logic [2:0] vowel;
      logic [3:0] tap;
      logic       filt_round;
      logic       mix_round;
      logic       emit;
   } fb_cmd_type;

   typedef struct packed {
      logic out_free;
   } fb_status_type;

endpackage

`default_nettype wire

[rtl/core/vowel_formant_filter_bank_unit.sv]
// ----------------------------------------------------------------------------
// vowel_formant_filter_bank_unit: five-vowel all-pole formant filter bank
// Runs five tenth-order all-pole filters (vowels A E I O U) on each audio
// sample and crossfades the two neighboring vowel outputs at the vowel
// position set by the control voltage or the position register.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Payload
// req_*     in         req_valid/req_stall sample_in, input_connected,
//                                          vowel_cv, cv_connected
// rsp_*     out        rsp_valid/rsp_stall sample_out
// csr_*     in         csr_valid/csr_ready vowel_position (Q3.16)
//
// An item with audio present runs in order: the divide by ten as a reciprocal
// product in four partial products and a step to take the quotient, then 55
// filter taps on the single shared 32x32 multiplier, each a fetch, an operand
// load and four partial products, a rounding step per vowel, two mix products
// of an operand load and four partial products each, and the final rounding
// and output load. The next input transfer is taken only after that load. An
// item with audio absent clears the histories and emits a zero result.
// Reset is synchronous and active high; it clears the histories (through
// their valid bits), the vowel position and the output valid flag.
// A stalled result sits in the output register while the next item is
// accepted and processed; the block only waits if that next result is ready
// before the previous one has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vowel_formant_filter_bank_unit (
   input  wire                      clock,
   input  wire                      reset,
   // Input items.
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire signed [23:0]        req_sample_in,
   input  wire                      req_input_connected,
   input  wire signed [23:0]        req_vowel_cv,
   input  wire                      req_cv_connected,
   // Results.
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic signed [23:0]       rsp_sample_out,
   // Position register write.
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire [vfb_pkg::POS_W-1:0] csr_vowel_position
);

   // The controller sequences every step; the datapath owns all arithmetic
   // and storage. They talk only through the command and status structs.
   vfb_pkg::fb_cmd_type    cmd;
   vfb_pkg::fb_status_type status;

   vfb_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_input_connected (req_input_connected),
      .req_stall           (req_stall),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .status              (status),
      .cmd                 (cmd)
   );

   // The history for each vowel is a ring of ten entries in one 50-entry
   // memory; a transfer with audio absent clears it by dropping valid bits.
   vfb_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_sample_in       (req_sample_in),
      .req_input_connected (req_input_connected),
      .req_vowel_cv        (req_vowel_cv),
      .req_cv_connected    (req_cv_connected),
      .csr_vowel_position  (csr_vowel_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sample_out      (rsp_sample_out)
   );

endmodule

`default_nettype wire

[rtl/core/vfb_ctrl.sv]
// ----------------------------------------------------------------------------
// vfb_ctrl: sequencer of the vowel filter bank
// Steps the shared multiplier through the divide, the 55 filter taps and the
// two mix products, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vfb_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_input_connected,
   output logic                  req_stall,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  vfb_pkg::fb_status_type status,
   output vfb_pkg::fb_cmd_type   cmd
);

   vfb_pkg::fb_state_type state_ff, state_in;
   logic [2:0] vowel_ff, vowel_in;
   logic [3:0] tap_ff, tap_in;
   logic [1:0] part_ff, part_in;
   logic       mix_sel_ff, mix_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= vfb_pkg::ST_IDLE;
         vowel_ff   <= '0;
         tap_ff     <= '0;
         part_ff    <= '0;
         mix_sel_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vowel_ff   <= vowel_in;
         tap_ff     <= tap_in;
         part_ff    <= part_in;
         mix_sel_ff <= mix_sel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      vowel_in   = vowel_ff;
      tap_in     = tap_ff;
      part_in    = part_ff;
      mix_sel_in = mix_sel_ff;
      cmd        = '0;
      cmd.part   = part_ff;
      cmd.vowel  = vowel_ff;
      cmd.tap    = tap_ff;
      cmd.src    = vfb_pkg::SRC_X;
      req_stall  = 1'b1;
      csr_ready  = 1'b0;

      unique case (state_ff)
         vfb_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            csr_ready     = 1'b1;
            cmd.cfg_write = csr_valid;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (!req_input_connected) begin
                  cmd.clear_hist = 1'b1;
                  state_in       = vfb_pkg::ST_EMIT;
               end else begin
                  part_in  = '0;
                  state_in = vfb_pkg::ST_DIVIDE;
               end
            end
         end
         vfb_pkg::ST_DIVIDE: begin
            cmd.mul = 1'b1;
            part_in = part_ff + 2'd1;
            if (part_ff == 2'd3) begin
               state_in = vfb_pkg::ST_DIV_DONE;
            end
         end
         vfb_pkg::ST_DIV_DONE: begin
            cmd.div_done = 1'b1;
            vowel_in     = '0;
            tap_in       = '0;
            state_in     = vfb_pkg::ST_FETCH;
         end
         vfb_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = vfb_pkg::ST_LOAD;
         end
         vfb_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            cmd.src  = (tap_ff == 4'd0) ? vfb_pkg::SRC_X : vfb_pkg::SRC_HIST;
            part_in  = '0;
            state_in = vfb_pkg::ST_MULT;
         end
         vfb_pkg::ST_MULT: begin
            cmd.mul = 1'b1;
            part_in = part_ff + 2'd1;
            if (part_ff == 2'd3) begin
               if (tap_ff == 4'(vfb_pkg::FILTER_ORDER)) begin
                  state_in = vfb_pkg::ST_FILT_ROUND;
               end else begin
                  tap_in   = tap_ff + 4'd1;
                  state_in = vfb_pkg::ST_FETCH;
               end
            end
         end
         vfb_pkg::ST_FILT_ROUND: begin
            cmd.filt_round = 1'b1;
            tap_in         = '0;
            if (vowel_ff == 3'(vfb_pkg::VOWEL_COUNT - 1)) begin
               mix_sel_in = 1'b0;
               state_in   = vfb_pkg::ST_MIX_LOAD;
            end else begin
               vowel_in = vowel_ff + 3'd1;
               state_in = vfb_pkg::ST_FETCH;
            end
         end
         vfb_pkg::ST_MIX_LOAD: begin
            cmd.load = 1'b1;
            cmd.src  = mix_sel_ff ? vfb_pkg::SRC_MIX_HI : vfb_pkg::SRC_MIX_LO;
            part_in  = '0;
            state_in = vfb_pkg::ST_MIX_MULT;
         end
         vfb_pkg::ST_MIX_MULT: begin
            cmd.mul = 1'b1;
            part_in = part_ff + 2'd1;
            if (part_ff == 2'd3) begin
               if (mix_sel_ff) begin
                  state_in = vfb_pkg::ST_MIX_ROUND;
               end else begin
                  mix_sel_in = 1'b1;
                  state_in   = vfb_pkg::ST_MIX_LOAD;
               end
            end
         end
         vfb_pkg::ST_MIX_ROUND: begin
            cmd.mix_round = 1'b1;
            state_in      = vfb_pkg::ST_EMIT;
         end
         vfb_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = vfb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vfb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/vfb_datapath.sv]
// ----------------------------------------------------------------------------
// vfb_datapath: arithmetic and storage of the vowel filter bank
// Reciprocal divide by ten, history memory with valid bits, a 32x32
// multiplier that builds each 64x64 product in four passes, a 128-bit
// accumulator, the rounding/saturation stages and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vfb_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  vfb_pkg::fb_cmd_type        cmd,
   output vfb_pkg::fb_status_type     status,
   input  wire signed [23:0]          req_sample_in,
   input  wire                        req_input_connected,
   input  wire signed [23:0]          req_vowel_cv,
   input  wire                        req_cv_connected,
   input  wire [vfb_pkg::POS_W-1:0]   csr_vowel_position,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [23:0]         rsp_sample_out
);

   localparam int AW = $clog2(vfb_pkg::HIST_DEPTH);

   // Control state.
   logic [vfb_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [vfb_pkg::HIST_DEPTH-1:0] hist_vld_ff, hist_vld_in;
   logic [3:0]                     head_ff, head_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Payload.
   logic [63:0]        hist_mem [vfb_pkg::HIST_DEPTH];
   logic [63:0]        hist_rd_ff;
   logic               rd_vld_ff;
   logic [47:0]        div_ff;
   logic               x_neg_ff;
   logic [63:0]        a_mag_ff;
   logic [63:0]        b_mag_ff;
   logic               neg_ff;
   logic [127:0]       acc_ff, acc_in;
   logic signed [63:0] o_lo_ff;
   logic signed [63:0] o_hi_ff;
   logic signed [23:0] result_ff;
   logic signed [23:0] rsp_data_ff;

   function automatic logic [63:0] mag64(input logic [63:0] a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   // Item start: magnitudes of the sample and the control voltage.
   logic [23:0] s_mag;
   logic [23:0] cv_mag;
   logic [24:0] cv_sum;
   logic [19:0] cv_pos;
   logic [18:0] cv_pos_clamped;
   logic [18:0] csr_clamped;

   always_comb begin
      s_mag          = req_sample_in[23] ? (~req_sample_in + 24'd1) : req_sample_in;
      cv_mag         = req_vowel_cv[23] ? (~req_vowel_cv + 24'd1) : req_vowel_cv;
      cv_sum         = {1'b0, cv_mag} + 25'd16;
      cv_pos         = cv_sum[24:5];
      cv_pos_clamped = (cv_pos > {1'b0, vfb_pkg::POS_MAX}) ? vfb_pkg::POS_MAX
                                                            : cv_pos[18:0];
      csr_clamped    = (csr_vowel_position > vfb_pkg::POS_MAX) ? vfb_pkg::POS_MAX
                                                                : csr_vowel_position;
   end

   // History addressing: circular per vowel, newest entry at the head.
   logic [3:0]    tap_m1;
   logic [4:0]    slot_sum;
   logic [3:0]    rd_slot;
   logic [3:0]    head_m1;
   logic [5:0]    base;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   always_comb begin
      tap_m1   = cmd.tap - 4'd1;
      slot_sum = {1'b0, head_ff} + {1'b0, tap_m1};
      rd_slot  = (slot_sum >= 5'd10) ? 4'(slot_sum - 5'd10) : slot_sum[3:0];
      head_m1  = (head_ff == 4'd0) ? 4'(vfb_pkg::FILTER_ORDER - 1) : head_ff - 4'd1;
      base     = {cmd.vowel, 3'b000} + {2'b00, cmd.vowel, 1'b0};
      rd_addr  = AW'(base + {2'b00, rd_slot});
      wr_addr  = AW'(base + {2'b00, head_m1});
   end

   // Operand selection.
   logic [63:0]  coef_sel;
   logic [63:0]  x_val;
   logic [63:0]  a_val;
   logic [63:0]  b_val;
   logic [15:0]  frac;
   logic [2:0]   seg;
   logic [16:0]  w_lo;

   always_comb begin
      coef_sel = vfb_pkg::COEF_TABLE[cmd.vowel][cmd.tap];
      x_val    = x_neg_ff ? (~{16'd0, div_ff} + 64'd1) : {16'd0, div_ff};
      frac     = pos_ff[15:0];
      seg      = pos_ff[18:16];
      w_lo     = 17'h10000 - {1'b0, frac};
      unique case (cmd.src)
         vfb_pkg::SRC_X: begin
            a_val = coef_sel;
            b_val = x_val;
         end
         vfb_pkg::SRC_HIST: begin
            a_val = coef_sel;
            b_val = rd_vld_ff ? hist_rd_ff : 64'd0;
         end
         vfb_pkg::SRC_MIX_LO: begin
            a_val = o_lo_ff;
            b_val = {47'd0, w_lo};
         end
         vfb_pkg::SRC_MIX_HI: begin
            a_val = o_hi_ff;
            b_val = {48'd0, frac};
         end
         default: begin
            a_val = '0;
            b_val = '0;
         end
      endcase
   end

   // One 32x32 partial product per cycle into the accumulator.
   logic [31:0]  a_half;
   logic [31:0]  b_half;
   logic [63:0]  pp;
   logic [127:0] term;

   always_comb begin
      a_half = cmd.part[0] ? a_mag_ff[63:32] : a_mag_ff[31:0];
      b_half = cmd.part[1] ? b_mag_ff[63:32] : b_mag_ff[31:0];
      pp     = a_half * b_half;
      unique case (cmd.part)
         2'd0:    term = {64'd0, pp};
         2'd3:    term = {pp, 64'd0};
         default: term = {32'd0, pp, 32'd0};
      endcase
      acc_in = acc_ff;
      if (cmd.start || cmd.div_done || cmd.filt_round) begin
         acc_in = '0;
      end else if (cmd.mul) begin
         acc_in = acc_ff + (neg_ff ? ~term : term) + {127'd0, neg_ff};
      end
   end

   // Rounding and saturation.
   logic [127:0]       filt_rounded;
   logic [74:0]        filt_shifted;
   logic signed [63:0] filt_res;
   logic [127:0]       mix_rounded;
   logic [87:0]        mix_shifted;
   logic signed [23:0] mix_res;

   always_comb begin
      filt_rounded = acc_ff + (128'd1 << (vfb_pkg::COEF_FRAC - 1));
      filt_shifted = filt_rounded[127:vfb_pkg::COEF_FRAC];
      if (filt_shifted[74:63] == {12{filt_shifted[63]}}) begin
         filt_res = filt_shifted[63:0];
      end else begin
         filt_res = filt_shifted[74] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      mix_rounded = acc_ff + (128'd1 << (vfb_pkg::MIX_FRAC - 1));
      mix_shifted = mix_rounded[127:vfb_pkg::MIX_FRAC];
      if (mix_shifted[87:23] == {65{mix_shifted[23]}}) begin
         mix_res = mix_shifted[23:0];
      end else begin
         mix_res = mix_shifted[87] ? 24'sh800000 : 24'sh7FFFFF;
      end
   end

   // Control state next values.
   always_comb begin
      pos_in      = pos_ff;
      hist_vld_in = hist_vld_ff;
      head_in     = head_ff;
      if (cmd.cfg_write) begin
         pos_in = csr_clamped;
      end
      if (cmd.start && req_input_connected && req_cv_connected) begin
         pos_in = cv_pos_clamped;
      end
      if (cmd.clear_hist) begin
         hist_vld_in = '0;
         head_in     = '0;
      end
      if (cmd.filt_round) begin
         hist_vld_in[wr_addr] = 1'b1;
         if (cmd.vowel == 3'(vfb_pkg::VOWEL_COUNT - 1)) begin
            head_in = head_m1;
         end
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hist_vld_ff  <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         hist_vld_ff  <= hist_vld_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // History memory: one write and one registered read per cycle. The gain
   // tap reads no history, so no read is made for it.
   always_ff @(posedge clock) begin
      if (cmd.filt_round) begin
         hist_mem[wr_addr] <= filt_res;
      end
      if (cmd.fetch && (cmd.tap != 4'd0)) begin
         hist_rd_ff <= hist_mem[rd_addr];
         rd_vld_ff  <= hist_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.start) begin
         // The divide by ten runs first on the shared multiplier.
         a_mag_ff  <= vfb_pkg::DIV_RECIP;
         b_mag_ff  <= {16'd0, s_mag, 24'd5};
         neg_ff    <= 1'b0;
         x_neg_ff  <= req_sample_in[23];
         o_lo_ff   <= '0;
         o_hi_ff   <= '0;
         result_ff <= '0;
      end
      if (cmd.div_done) begin
         div_ff <= acc_ff[vfb_pkg::DIV_SHIFT +: 48];
      end
      if (cmd.load) begin
         a_mag_ff <= mag64(a_val);
         b_mag_ff <= mag64(b_val);
         neg_ff   <= a_val[63] ^ b_val[63];
      end
      if (cmd.filt_round) begin
         if (cmd.vowel == seg) begin
            o_lo_ff <= filt_res;
         end
         if (cmd.vowel == seg + 3'd1) begin
            o_hi_ff <= filt_res;
         end
      end
      if (cmd.mix_round) begin
         result_ff <= mix_res;
      end
      if (cmd.emit) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/vfb_checker.sv]
// ----------------------------------------------------------------------------
// vfb_checker: port-level checks of the vowel filter bank
// Watches the top-level ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module vfb_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_valid,
   input wire                      req_stall,
   input wire signed [23:0]        req_sample_in,
   input wire                      req_input_connected,
   input wire signed [23:0]        req_vowel_cv,
   input wire                      req_cv_connected,
   input wire                      rsp_valid,
   input wire                      rsp_stall,
   input wire signed [23:0]        rsp_sample_out,
   input wire                      csr_valid,
   input wire                      csr_ready
);

   // No result is left over from before reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays and holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("stalled result changed");

   // A waiting input item stays offered with the same payload.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_sample_in)
         && $stable(req_input_connected) && $stable(req_vowel_cv)
         && $stable(req_cv_connected)))
      else $error("stalled input item changed");

   // One item at a time: after an input transfer the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second input transfer while busy");

   // The register port is ready exactly when the input port is.
   assert property (@(posedge clock) disable iff (reset)
      csr_ready == !req_stall)
      else $error("register port ready differs from input readiness");

endmodule

bind vowel_formant_filter_bank_unit vfb_checker u_vfb_checker (.*);

`default_nettype wire
